>>> hdl/tphi_pkg.sv
`timescale 1ns / 1ps
// shared widths, types and constants for the triangle height interpolator
package tphi_pkg;

  localparam int CoordWidth = 32;
  localparam int FracBits   = 16;
  localparam int RatioBits  = 30;
  localparam int TolWidth   = 16;
  localparam int Tol2Width  = 2 * TolWidth;

  // edge vectors, cross products and the divider datapath
  localparam int DiffWidth  = CoordWidth + 1;
  localparam int ProdWidth  = 2 * DiffWidth;
  localparam int CrossWidth = ProdWidth + 1;
  localparam int DivWidth   = CrossWidth + 1;
  localparam int QuotWidth  = RatioBits + 1;
  localparam int DivStages  = RatioBits + 1;

  // interpolation datapath
  localparam int ScaleWidth = DiffWidth + QuotWidth + 1;
  localparam int SpanWidth  = CoordWidth + 2;
  localparam int SqWidth    = 2 * SpanWidth;
  localparam int DistWidth  = SqWidth + 1;
  localparam int ZdWidth    = SpanWidth + 1;
  localparam int ZpWidth    = ZdWidth + QuotWidth + 1;

  localparam int NumCross   = 9;

  localparam logic [TolWidth-1:0] SnapReset =
    TolWidth'(((1 << FracBits) + 5000) / 10000);
  localparam logic [QuotWidth-1:0] QuotOne = QuotWidth'(1) << RatioBits;

  typedef logic signed [CoordWidth-1:0] coord_t;
  typedef logic signed [DiffWidth-1:0]  diff_t;
  typedef logic signed [ProdWidth-1:0]  prod_t;
  typedef logic signed [CrossWidth-1:0] cross_t;
  typedef logic        [DivWidth-1:0]   div_t;
  typedef logic        [QuotWidth-1:0]  quot_t;
  typedef logic        [TolWidth-1:0]   tol_t;
  typedef logic        [Tol2Width-1:0]  tol2_t;

  // item data that rides alongside the ratio divider
  typedef struct packed {
    logic   in_tri;
    logic   hval;
    logic   snap_c;
    coord_t ax;
    coord_t ay;
    coord_t az;
    coord_t bx;
    coord_t by;
    coord_t bz;
    coord_t cz;
    coord_t px;
    coord_t py;
    diff_t  ex;
    diff_t  ey;
    diff_t  ez;
  } side_t;

  function automatic diff_t ext_coord(input coord_t v);
    return {v[CoordWidth-1], v};
  endfunction

endpackage

>>> hdl/tphi_in_if.sv
`timescale 1ns / 1ps
// item channel: triangle vertices and query point
interface tphi_in_if;
  import tphi_pkg::*;

  logic   valid;
  logic   ready;
  coord_t a_x;
  coord_t a_y;
  coord_t a_z;
  coord_t b_x;
  coord_t b_y;
  coord_t b_z;
  coord_t c_x;
  coord_t c_y;
  coord_t c_z;
  coord_t point_x;
  coord_t point_y;

  modport source (
    output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, point_x, point_y,
    input  ready
  );
  modport sink (
    input  valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, point_x, point_y,
    output ready
  );
endinterface

>>> hdl/tphi_out_if.sv
`timescale 1ns / 1ps
// result channel: inside flag and interpolated height
interface tphi_out_if;
  import tphi_pkg::*;

  logic   valid;
  logic   ready;
  logic   inside_res;
  logic   height_valid;
  coord_t height;

  modport source (output valid, inside_res, height_valid, height, input ready);
  modport sink (input valid, inside_res, height_valid, height, output ready);
endinterface

>>> hdl/tphi_cfg_if.sv
`timescale 1ns / 1ps
// configuration write channel for the snap tolerance
interface tphi_cfg_if;
  import tphi_pkg::*;

  logic valid;
  logic ready;
  tol_t snap_tolerance;

  modport source (output valid, snap_tolerance, input ready);
  modport sink (input valid, snap_tolerance, output ready);
endinterface

>>> hdl/tphi_div.sv
`timescale 1ns / 1ps
// two-lane pipelined restoring divider for unsigned fractions, one bit per stage
module tphi_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  tphi_pkg::div_t  [1:0]    num_i,
  input  tphi_pkg::div_t  [1:0]    den_i,
  input  tphi_pkg::side_t          side_i,
  output logic                     valid_o,
  output tphi_pkg::quot_t [1:0]    quot_o,
  output tphi_pkg::side_t          side_o
);
  import tphi_pkg::*;

  logic         vld_q  [DivStages+1];
  div_t  [1:0]  rem_q  [DivStages+1];
  div_t  [1:0]  den_q  [DivStages+1];
  quot_t [1:0]  quo_q  [DivStages+1];
  logic  [1:0]  full_q [DivStages+1];
  side_t        side_q [DivStages+1];

  // entry: a numerator not below its divisor saturates to one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < 2; l++) begin
        rem_q[0][l]  <= num_i[l];
        den_q[0][l]  <= den_i[l];
        quo_q[0][l]  <= '0;
        full_q[0][l] <= (num_i[l] >= den_i[l]);
      end
      side_q[0] <= side_i;
    end
  end

  for (genvar g = 0; g < DivStages; g++) begin : g_step
    div_t [1:0] dbl;
    logic [1:0] take;

    always_comb begin
      for (int l = 0; l < 2; l++) begin
        dbl[l]  = {rem_q[g][l][DivWidth-2:0], 1'b0};
        take[l] = (dbl[l] >= den_q[g][l]);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[g+1] <= vld_q[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int l = 0; l < 2; l++) begin
          rem_q[g+1][l] <= take[l] ? (dbl[l] - den_q[g][l]) : dbl[l];
          quo_q[g+1][l] <= {quo_q[g][l][QuotWidth-2:0], take[l]};
        end
        den_q[g+1]  <= den_q[g];
        full_q[g+1] <= full_q[g];
        side_q[g+1] <= side_q[g];
      end
    end
  end

  // one guard bit, rounded half up
  always_comb begin
    logic [QuotWidth:0] inc;
    for (int l = 0; l < 2; l++) begin
      inc       = {1'b0, quo_q[DivStages][l]} + (QuotWidth+1)'(1);
      quot_o[l] = full_q[DivStages][l] ? QuotOne : inc[QuotWidth:1];
    end
  end

  assign valid_o = vld_q[DivStages];
  assign side_o  = side_q[DivStages];

endmodule

>>> hdl/triangle_point_height_interpolator_unit.sv
`timescale 1ns / 1ps
// top level: point-in-triangle test and ray/edge height interpolation
//
//   channel | dir | transfer when       | payload
//   --------+-----+---------------------+-----------------------------------------
//   in_i    | in  | valid && ready      | a/b/c x,y,z and point x,y, Q16.16
//   out_o   | out | valid && ready      | inside_res, height_valid, height
//   cfg_i   | in  | valid && ready      | snap_tolerance (ready is always high)
//
// one item per cycle unless a result held in the output register stalls the pipeline;
// the 31-step divider forms both interpolation ratios
// a result held in the output register freezes every stage until it is taken,
// so in_i.ready follows out_o.ready whenever the output register is full
// reset empties the pipeline and loads the snap tolerance with 7
module triangle_point_height_interpolator_unit (
  input logic clk_i,
  input logic rst_ni,
  tphi_in_if.sink    in_i,
  tphi_out_if.source out_o,
  tphi_cfg_if.sink   cfg_i
);
  import tphi_pkg::*;

  // cross product lanes
  localparam int LnAbC = 0;  // edge ab towards c
  localparam int LnAbP = 1;  // edge ab towards point
  localparam int LnBcA = 2;  // edge bc towards a
  localparam int LnBcP = 3;  // edge bc towards point
  localparam int LnCaB = 4;  // edge ca towards b
  localparam int LnSn  = 5;  // edge ca towards point, also the segment numerator
  localparam int LnDen = 6;  // ray x segment
  localparam int LnTn  = 7;  // ray parameter numerator
  localparam int LnCp  = 8;  // squared distance c to point

  localparam int RsWidth = ScaleWidth - RatioBits;
  localparam int HsWidth = ZpWidth - RatioBits;

  localparam logic signed [ScaleWidth-1:0] HalfS = ScaleWidth'(1) << (RatioBits - 1);
  localparam logic signed [ZpWidth-1:0]    HalfZ = ZpWidth'(1) << (RatioBits - 1);

  // squared-distance lanes after the divider
  localparam int DqAx = 0;
  localparam int DqAy = 1;
  localparam int DqBx = 2;
  localparam int DqBy = 3;
  localparam int DqPx = 4;
  localparam int DqPy = 5;

  logic en;

  // ---------------------------------------------------------------- config
  tol_t  snap_q;
  tol2_t tol2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_q <= SnapReset;
      tol2_q <= Tol2Width'(SnapReset) * Tol2Width'(SnapReset);
    end else begin
      if (cfg_i.valid) begin
        snap_q <= cfg_i.snap_tolerance;
      end
      // squared tolerance, follows the register in the next cycle
      tol2_q <= Tol2Width'(snap_q) * Tol2Width'(snap_q);
    end
  end

  assign cfg_i.ready = 1'b1;

  // whole pipeline advances unless a result waits in the output register
  logic out_vld_q;
  assign en         = !out_vld_q || out_o.ready;
  assign in_i.ready = en;

  // ---------------------------------------------------------------- s1: edge vectors
  diff_t ux_d [NumCross];
  diff_t uy_d [NumCross];
  diff_t vx_d [NumCross];
  diff_t vy_d [NumCross];
  side_t s1_side_d;

  always_comb begin
    diff_t ax, ay, bx, by, cx, cy, px, py;
    diff_t ex, ey, dx, dy, wx, wy;
    ax = ext_coord(in_i.a_x);
    ay = ext_coord(in_i.a_y);
    bx = ext_coord(in_i.b_x);
    by = ext_coord(in_i.b_y);
    cx = ext_coord(in_i.c_x);
    cy = ext_coord(in_i.c_y);
    px = ext_coord(in_i.point_x);
    py = ext_coord(in_i.point_y);
    ex = bx - ax;
    ey = by - ay;
    dx = px - cx;
    dy = py - cy;
    wx = ax - cx;
    wy = ay - cy;

    ux_d[LnAbC] = ex;       uy_d[LnAbC] = ey;
    vx_d[LnAbC] = cx - ax;  vy_d[LnAbC] = cy - ay;
    ux_d[LnAbP] = ex;       uy_d[LnAbP] = ey;
    vx_d[LnAbP] = px - ax;  vy_d[LnAbP] = py - ay;
    ux_d[LnBcA] = cx - bx;  uy_d[LnBcA] = cy - by;
    vx_d[LnBcA] = ax - bx;  vy_d[LnBcA] = ay - by;
    ux_d[LnBcP] = cx - bx;  uy_d[LnBcP] = cy - by;
    vx_d[LnBcP] = px - bx;  vy_d[LnBcP] = py - by;
    ux_d[LnCaB] = wx;       uy_d[LnCaB] = wy;
    vx_d[LnCaB] = bx - cx;  vy_d[LnCaB] = by - cy;
    ux_d[LnSn]  = wx;       uy_d[LnSn]  = wy;
    vx_d[LnSn]  = dx;       vy_d[LnSn]  = dy;
    ux_d[LnDen] = dx;       uy_d[LnDen] = dy;
    vx_d[LnDen] = ex;       vy_d[LnDen] = ey;
    ux_d[LnTn]  = wx;       uy_d[LnTn]  = wy;
    vx_d[LnTn]  = ex;       vy_d[LnTn]  = ey;
    // cross of (dx, dy) with (-dy, dx) is dx*dx + dy*dy
    ux_d[LnCp]  = dx;       uy_d[LnCp]  = dy;
    vx_d[LnCp]  = -dy;      vy_d[LnCp]  = dx;

    s1_side_d.in_tri = 1'b0;
    s1_side_d.hval   = 1'b0;
    s1_side_d.snap_c = 1'b0;
    s1_side_d.ax     = in_i.a_x;
    s1_side_d.ay     = in_i.a_y;
    s1_side_d.az     = in_i.a_z;
    s1_side_d.bx     = in_i.b_x;
    s1_side_d.by     = in_i.b_y;
    s1_side_d.bz     = in_i.b_z;
    s1_side_d.cz     = in_i.c_z;
    s1_side_d.px     = in_i.point_x;
    s1_side_d.py     = in_i.point_y;
    s1_side_d.ex     = ex;
    s1_side_d.ey     = ey;
    s1_side_d.ez     = ext_coord(in_i.b_z) - ext_coord(in_i.a_z);
  end

  logic   s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q, s5_vld_q;
  side_t  s1_side_q, s2_side_q, s3_side_q, s4_side_q, s5_side_q;
  diff_t  s1_ux_q [NumCross];
  diff_t  s1_uy_q [NumCross];
  diff_t  s1_vx_q [NumCross];
  diff_t  s1_vy_q [NumCross];
  prod_t  s2_m0_q [NumCross];
  prod_t  s2_m1_q [NumCross];
  cross_t s3_cr_q [NumCross];
  cross_t s4_den_q, s4_tn_q, s4_sn_q;
  div_t [1:0] s5_num_q, s5_den_q;

  // ---------------------------------------------------------------- s4/s5 logic
  side_t      s4_side_d, s5_side_d;
  cross_t     s4_den_d, s4_tn_d, s4_sn_d;
  div_t [1:0] s5_num_d, s5_den_d;

  function automatic logic opposite(input cross_t a, input cross_t b);
    logic an, ap, bn, bp;
    an = a[CrossWidth-1];
    ap = !an && (|a);
    bn = b[CrossWidth-1];
    bp = !bn && (|b);
    return (an && bp) || (ap && bn);
  endfunction

  always_comb begin
    logic flip;
    s4_side_d        = s3_side_q;
    s4_side_d.in_tri = !opposite(s3_cr_q[LnAbC], s3_cr_q[LnAbP]) &&
                       !opposite(s3_cr_q[LnBcA], s3_cr_q[LnBcP]) &&
                       !opposite(s3_cr_q[LnCaB], s3_cr_q[LnSn]);
    s4_side_d.snap_c = $unsigned(s3_cr_q[LnCp]) < CrossWidth'(tol2_q);
    // orient so that the ray x segment cross product is not negative
    flip     = s3_cr_q[LnDen][CrossWidth-1];
    s4_den_d = flip ? -s3_cr_q[LnDen] : s3_cr_q[LnDen];
    s4_tn_d  = flip ? -s3_cr_q[LnTn]  : s3_cr_q[LnTn];
    s4_sn_d  = flip ? -s3_cr_q[LnSn]  : s3_cr_q[LnSn];
  end

  always_comb begin
    logic tge;
    div_t den_u, tn_u;
    den_u = DivWidth'($unsigned(s4_den_q));
    tn_u  = DivWidth'($unsigned(s4_tn_q));
    tge   = (s4_tn_q >= s4_den_q);
    s5_side_d      = s4_side_q;
    s5_side_d.hval = (|s4_den_q) && !s4_tn_q[CrossWidth-1] && !s4_sn_q[CrossWidth-1] &&
                     (s4_sn_q <= s4_den_q);
    // lane 0: segment parameter s; lane 1: |cp| / (|cp| + |pi|)
    s5_num_d[0] = DivWidth'($unsigned(s4_sn_q));
    s5_den_d[0] = den_u;
    s5_num_d[1] = den_u;
    s5_den_d[1] = tge ? tn_u : ((den_u << 1) - tn_u);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
      s5_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= in_i.valid;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
      s5_vld_q <= s4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < NumCross; k++) begin
        s1_ux_q[k] <= ux_d[k];
        s1_uy_q[k] <= uy_d[k];
        s1_vx_q[k] <= vx_d[k];
        s1_vy_q[k] <= vy_d[k];
        s2_m0_q[k] <= ProdWidth'(s1_ux_q[k]) * ProdWidth'(s1_vy_q[k]);
        s2_m1_q[k] <= ProdWidth'(s1_uy_q[k]) * ProdWidth'(s1_vx_q[k]);
        s3_cr_q[k] <= CrossWidth'(s2_m0_q[k]) - CrossWidth'(s2_m1_q[k]);
      end
      s1_side_q <= s1_side_d;
      s2_side_q <= s1_side_q;
      s3_side_q <= s2_side_q;
      s4_side_q <= s4_side_d;
      s4_den_q  <= s4_den_d;
      s4_tn_q   <= s4_tn_d;
      s4_sn_q   <= s4_sn_d;
      s5_side_q <= s5_side_d;
      s5_num_q  <= s5_num_d;
      s5_den_q  <= s5_den_d;
    end
  end

  // ---------------------------------------------------------------- ratio divider
  logic        dv_vld;
  quot_t [1:0] dv_quot;
  side_t       dv_side;

  tphi_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s5_vld_q),
    .num_i   (s5_num_q),
    .den_i   (s5_den_q),
    .side_i  (s5_side_q),
    .valid_o (dv_vld),
    .quot_o  (dv_quot),
    .side_o  (dv_side)
  );

  // ---------------------------------------------------------------- interpolation
  logic  t1_vld_q, t2_vld_q, t3_vld_q, t4_vld_q, t5_vld_q, t6_vld_q, t7_vld_q;
  side_t t1_side_q, t2_side_q, t3_side_q, t4_side_q, t5_side_q, t6_side_q, t7_side_q;
  quot_t t1_rq_q, t2_rq_q, t3_rq_q, t4_rq_q, t5_rq_q, t6_rq_q;
  logic signed [ScaleWidth-1:0] t1_pex_q, t1_pey_q, t1_pez_q;
  logic signed [SpanWidth-1:0]  t2_ix_q, t2_iy_q, t2_zl_q;
  logic signed [SpanWidth-1:0]  t3_zl_q, t4_zl_q, t5_zl_q;
  logic signed [SpanWidth-1:0]  t3_d_q  [6];
  logic        [SqWidth-1:0]    t4_sq_q [6];
  logic                         t5_snap_a_q, t5_snap_b_q, t5_snap_p_q;
  logic                         t6_snap_p_q, t7_snap_p_q;
  logic signed [SpanWidth-1:0]  t6_zi_q, t7_zi_q;
  logic signed [ZdWidth-1:0]    t6_zd_q;
  logic signed [ZpWidth-1:0]    t7_zp_q;

  // t2: round the products back to the coordinate grid
  logic signed [SpanWidth-1:0] t2_ix_d, t2_iy_d, t2_zl_d;

  function automatic logic signed [SpanWidth-1:0] scale_add(
    input coord_t base, input logic signed [ScaleWidth-1:0] p);
    logic signed [ScaleWidth-1:0] biased;
    logic signed [RsWidth-1:0]    sum;
    biased = p + HalfS;
    sum    = RsWidth'(base) + $signed(biased[ScaleWidth-1:RatioBits]);
    return sum[SpanWidth-1:0];
  endfunction

  always_comb begin
    t2_ix_d = scale_add(t1_side_q.ax, t1_pex_q);
    t2_iy_d = scale_add(t1_side_q.ay, t1_pey_q);
    t2_zl_d = scale_add(t1_side_q.az, t1_pez_q);
  end

  // t5: endpoint snaps on the crossing point
  logic t5_snap_a_d, t5_snap_b_d, t5_snap_p_d;

  always_comb begin
    logic [DistWidth-1:0] da, db, dp, tl;
    tl = DistWidth'(tol2_q);
    da = DistWidth'(t4_sq_q[DqAx]) + DistWidth'(t4_sq_q[DqAy]);
    db = DistWidth'(t4_sq_q[DqBx]) + DistWidth'(t4_sq_q[DqBy]);
    dp = DistWidth'(t4_sq_q[DqPx]) + DistWidth'(t4_sq_q[DqPy]);
    t5_snap_a_d = da < tl;
    t5_snap_b_d = db < tl;
    t5_snap_p_d = dp < tl;
  end

  // t6: height at the crossing point
  logic signed [SpanWidth-1:0] t6_zi_d;
  assign t6_zi_d = t5_snap_a_q ? SpanWidth'(t5_side_q.az) :
                   t5_snap_b_q ? SpanWidth'(t5_side_q.bz) : t5_zl_q;

  // output stage: height at the point, snapped and saturated, or zero without a valid height
  coord_t out_height_d;

  always_comb begin
    logic signed [ZpWidth-1:0] biased;
    logic signed [HsWidth-1:0] lerp, hsel;
    biased = t7_zp_q + HalfZ;
    lerp   = HsWidth'(t7_side_q.cz) + $signed(biased[ZpWidth-1:RatioBits]);
    hsel   = t7_side_q.snap_c ? HsWidth'(t7_side_q.cz) :
             t7_snap_p_q      ? HsWidth'(t7_zi_q)      : lerp;
    if (!t7_side_q.hval) begin
      out_height_d = '0;
    end else if (hsel[HsWidth-1:CoordWidth-1] == '0 ||
                 hsel[HsWidth-1:CoordWidth-1] == '1) begin
      out_height_d = hsel[CoordWidth-1:0];
    end else begin
      out_height_d = hsel[HsWidth-1] ? {1'b1, {(CoordWidth-1){1'b0}}}
                                     : {1'b0, {(CoordWidth-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_vld_q  <= 1'b0;
      t2_vld_q  <= 1'b0;
      t3_vld_q  <= 1'b0;
      t4_vld_q  <= 1'b0;
      t5_vld_q  <= 1'b0;
      t6_vld_q  <= 1'b0;
      t7_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      t1_vld_q  <= dv_vld;
      t2_vld_q  <= t1_vld_q;
      t3_vld_q  <= t2_vld_q;
      t4_vld_q  <= t3_vld_q;
      t5_vld_q  <= t4_vld_q;
      t6_vld_q  <= t5_vld_q;
      t7_vld_q  <= t6_vld_q;
      out_vld_q <= t7_vld_q;
    end
  end

  logic   out_inside_q, out_hval_q;
  coord_t out_height_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      // t1: scale edge ab by s
      t1_side_q <= dv_side;
      t1_rq_q   <= dv_quot[1];
      t1_pex_q  <= ScaleWidth'(dv_side.ex) * ScaleWidth'($signed({1'b0, dv_quot[0]}));
      t1_pey_q  <= ScaleWidth'(dv_side.ey) * ScaleWidth'($signed({1'b0, dv_quot[0]}));
      t1_pez_q  <= ScaleWidth'(dv_side.ez) * ScaleWidth'($signed({1'b0, dv_quot[0]}));
      // t2: crossing point and lerped height on ab
      t2_side_q <= t1_side_q;
      t2_rq_q   <= t1_rq_q;
      t2_ix_q   <= t2_ix_d;
      t2_iy_q   <= t2_iy_d;
      t2_zl_q   <= t2_zl_d;
      // t3: offsets from the crossing point
      t3_side_q     <= t2_side_q;
      t3_rq_q       <= t2_rq_q;
      t3_zl_q       <= t2_zl_q;
      t3_d_q[DqAx]  <= SpanWidth'(t2_side_q.ax) - t2_ix_q;
      t3_d_q[DqAy]  <= SpanWidth'(t2_side_q.ay) - t2_iy_q;
      t3_d_q[DqBx]  <= SpanWidth'(t2_side_q.bx) - t2_ix_q;
      t3_d_q[DqBy]  <= SpanWidth'(t2_side_q.by) - t2_iy_q;
      t3_d_q[DqPx]  <= SpanWidth'(t2_side_q.px) - t2_ix_q;
      t3_d_q[DqPy]  <= SpanWidth'(t2_side_q.py) - t2_iy_q;
      // t4: squares
      t4_side_q <= t3_side_q;
      t4_rq_q   <= t3_rq_q;
      t4_zl_q   <= t3_zl_q;
      for (int j = 0; j < 6; j++) begin
        t4_sq_q[j] <= SqWidth'(t3_d_q[j]) * SqWidth'(t3_d_q[j]);
      end
      // t5: distance compares
      t5_side_q   <= t4_side_q;
      t5_rq_q     <= t4_rq_q;
      t5_zl_q     <= t4_zl_q;
      t5_snap_a_q <= t5_snap_a_d;
      t5_snap_b_q <= t5_snap_b_d;
      t5_snap_p_q <= t5_snap_p_d;
      // t6: pick height at crossing, span from c
      t6_side_q   <= t5_side_q;
      t6_rq_q     <= t5_rq_q;
      t6_snap_p_q <= t5_snap_p_q;
      t6_zi_q     <= t6_zi_d;
      t6_zd_q     <= ZdWidth'(t6_zi_d) - ZdWidth'(t5_side_q.cz);
      // t7: scale span by r
      t7_side_q   <= t6_side_q;
      t7_snap_p_q <= t6_snap_p_q;
      t7_zi_q     <= t6_zi_q;
      t7_zp_q     <= ZpWidth'(t6_zd_q) * ZpWidth'($signed({1'b0, t6_rq_q}));
      // output register
      out_inside_q <= t7_side_q.in_tri;
      out_hval_q   <= t7_side_q.hval;
      out_height_q <= out_height_d;
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.inside_res   = out_inside_q;
  assign out_o.height_valid = out_hval_q;
  assign out_o.height       = out_height_q;

endmodule

>>> hdl/tphi_checker.sv
`timescale 1ns / 1ps
// port-level checks for the triangle height interpolator, with its bind
module tphi_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic             out_height_valid_i,
  input tphi_pkg::coord_t out_height_i
);
  import tphi_pkg::*;

  // a result not taken stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_height_i))
    else $error("held result changed");

  // invalid height reads as zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_height_valid_i |-> out_height_i == '0)
    else $error("invalid height not zero");

  // input side only stalls while a result waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i == (!out_valid_i || out_ready_i))
    else $error("input stalled without output backpressure");

  // handshake outputs are known whenever an item is offered, once out of reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i |-> !$isunknown({out_valid_i, in_ready_i}))
    else $error("handshake output unknown");

endmodule

bind triangle_point_height_interpolator_unit tphi_checker u_tphi_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_i.valid),
  .in_ready_i         (in_i.ready),
  .out_valid_i        (out_o.valid),
  .out_ready_i        (out_o.ready),
  .out_height_valid_i (out_o.height_valid),
  .out_height_i       (out_o.height)
);

>>> dv/tphi_tb_pkg.sv
`timescale 1ns / 1ps
// height prediction and result bookkeeping for the interpolator bench
package tphi_tb_pkg;
  import tphi_pkg::*;

  typedef struct {
    coord_t ax, ay, az, bx, by, bz, cx, cy, cz, px, py;
  } tri_item_t;

  typedef struct {
    logic   in_tri;
    logic   hval;
    coord_t height;
  } height_res_t;

  typedef logic signed [159:0] wide_t;

  // ratio num/den with 30 fraction bits, rounded half up
  function automatic longint calc_ratio(wide_t num, wide_t den);
    longint unsigned q;
    q = 0;
    if (num >= den) return longint'(1) << 30;
    for (int i = 0; i < 31; i++) begin
      num = num + num;
      q = q << 1;
      if (num >= den) begin
        num = num - den;
        q = q | 1;
      end
    end
    return longint'((q + 1) >> 1);
  endfunction

  // signed product shifted down by 30, half up
  function automatic longint scale_round(longint a, longint q);
    wide_t p;
    p = wide_t'(a) * wide_t'(q) + (wide_t'(1) <<< 29);
    return longint'(p >>> 30);
  endfunction

  function automatic wide_t xprod(longint ux, longint uy, longint vx, longint vy);
    return wide_t'(ux) * wide_t'(vy) - wide_t'(uy) * wide_t'(vx);
  endfunction

  function automatic wide_t dsq(longint dx, longint dy);
    return wide_t'(dx) * wide_t'(dx) + wide_t'(dy) * wide_t'(dy);
  endfunction

  function automatic int sgn(wide_t v);
    return v < 0 ? -1 : (v == 0 ? 0 : 1);
  endfunction

  function automatic bit edge_ok(longint ax, longint ay, longint bx, longint by,
                                 longint cx, longint cy, longint px, longint py);
    return sgn(xprod(bx - ax, by - ay, cx - ax, cy - ay)) *
           sgn(xprod(bx - ax, by - ay, px - ax, py - ay)) >= 0;
  endfunction

  function automatic height_res_t predict_height(tri_item_t it, tol_t tol);
    height_res_t r;
    longint ax, ay, az, bx, by, bz, cx, cy, cz, px, py;
    longint dx, dy, ex, ey, wx, wy, sq, rq, ix, iy, zi, h;
    wide_t den, tn, sn, t2;
    ax = it.ax; ay = it.ay; az = it.az; bx = it.bx; by = it.by; bz = it.bz;
    cx = it.cx; cy = it.cy; cz = it.cz; px = it.px; py = it.py;
    dx = px - cx; dy = py - cy; ex = bx - ax; ey = by - ay;
    wx = ax - cx; wy = ay - cy;
    h = 0;
    r.in_tri = edge_ok(ax, ay, bx, by, cx, cy, px, py) &&
               edge_ok(bx, by, cx, cy, ax, ay, px, py) &&
               edge_ok(cx, cy, ax, ay, bx, by, px, py);
    den = xprod(dx, dy, ex, ey);
    tn = xprod(wx, wy, ex, ey);
    sn = xprod(wx, wy, dx, dy);
    if (den < 0) begin
      den = -den; tn = -tn; sn = -sn;
    end
    r.hval = den != 0 && tn >= 0 && sn >= 0 && sn <= den;
    if (r.hval) begin
      t2 = wide_t'(tol) * wide_t'(tol);
      sq = calc_ratio(sn, den);
      ix = ax + scale_round(ex, sq);
      iy = ay + scale_round(ey, sq);
      if (dsq(ax - ix, ay - iy) < t2) zi = az;
      else if (dsq(bx - ix, by - iy) < t2) zi = bz;
      else zi = az + scale_round(bz - az, sq);
      if (tn >= den) rq = calc_ratio(den, tn);
      else rq = calc_ratio(den, den + den - tn);
      if (dsq(dx, dy) < t2) h = cz;
      else if (dsq(px - ix, py - iy) < t2) h = zi;
      else h = cz + scale_round(zi - cz, rq);
      if (h > 64'sh7FFFFFFF) h = 64'sh7FFFFFFF;
      if (h < -64'sh80000000) h = -64'sh80000000;
    end
    r.height = coord_t'(h);
    return r;
  endfunction

  class height_board;
    height_res_t pending[$];
    tol_t        tol;
    int          errors;
    int          taken;

    function new();
      tol = SnapReset;
    endfunction

    function void note_item(tri_item_t it);
      pending = {pending, predict_height(it, tol)};
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(height_res_t got);
      height_res_t want;
      taken++;
      if (pending.size() == 0) begin
        report($sformatf("result %0d with nothing pending", taken));
        return;
      end
      want = pending.pop_front();
      if (got.in_tri !== want.in_tri)
        report($sformatf("result %0d inside %b want %b", taken, got.in_tri, want.in_tri));
      if (got.hval !== want.hval)
        report($sformatf("result %0d height_valid %b want %b", taken, got.hval, want.hval));
      if (got.height !== want.height)
        report($sformatf("result %0d height %h want %h", taken, got.height, want.height));
    endtask
  endclass
endpackage

>>> dv/triangle_point_height_interpolator_unit_tb.sv
`timescale 1ns / 1ps
// bench for the interpolator: directed and random triangles, random stalls
module triangle_point_height_interpolator_unit_tb;
  import tphi_pkg::*;
  import tphi_tb_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   cycles = 0;
  height_board board = new();

  tphi_in_if  in_if();
  tphi_out_if out_if();
  tphi_cfg_if cfg_if();

  triangle_point_height_interpolator_unit dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if.sink),
    .out_o (out_if.source),
    .cfg_i (cfg_if.sink)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    in_if.valid = 1'b0;
    {in_if.a_x, in_if.a_y, in_if.a_z, in_if.b_x, in_if.b_y, in_if.b_z} = '0;
    {in_if.c_x, in_if.c_y, in_if.c_z, in_if.point_x, in_if.point_y} = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.snap_tolerance = '0;
  end

  // result side: random stalls, with calm stretches
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready)
      board.check_result('{out_if.inside_res, out_if.height_valid, out_if.height});
  end

  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_if.valid) @(posedge clk_i);
    end
  end

  // one item transfer, after a random gap unless calm
  task automatic send_item(tri_item_t it, bit calm);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.a_x <= it.ax; in_if.a_y <= it.ay; in_if.a_z <= it.az;
    in_if.b_x <= it.bx; in_if.b_y <= it.by; in_if.b_z <= it.bz;
    in_if.c_x <= it.cx; in_if.c_y <= it.cy; in_if.c_z <= it.cz;
    in_if.point_x <= it.px; in_if.point_y <= it.py;
    do @(posedge clk_i); while (!in_if.ready);
    board.note_item(it);
  endtask

  // tolerance write only with the pipeline drained
  task automatic set_tolerance(tol_t v);
    in_if.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.snap_tolerance <= v;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    board.tol = v;
  endtask

  function automatic coord_t rand_coord(int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
      2: return coord_t'($signed($urandom_range(0, 400)) - 200);
      default: return coord_t'($signed($urandom_range(0, 200000)) - 100000) <<< 10;
    endcase
  endfunction

  // mostly triangles with the point near or inside, some wild ones
  function automatic tri_item_t rand_item();
    tri_item_t it;
    int mode, w0, w1, w2;
    longint sx, sy;
    mode = $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 3);
    it.ax = rand_coord(mode); it.ay = rand_coord(mode);
    it.bx = rand_coord(mode); it.by = rand_coord(mode);
    it.cx = rand_coord(mode); it.cy = rand_coord(mode);
    it.az = rand_coord($urandom_range(0, 3)); it.bz = rand_coord($urandom_range(0, 3));
    it.cz = rand_coord($urandom_range(0, 3));
    case ($urandom_range(0, 7))
      0: begin it.px = rand_coord(mode); it.py = rand_coord(mode); end
      1: begin it.px = it.cx; it.py = it.cy; end
      2: begin
        it.bx = it.ax; it.by = it.ay;
        it.px = rand_coord(mode); it.py = rand_coord(mode);
      end
      3: begin it.px = it.ax + $signed($urandom_range(0, 6)) - 3; it.py = it.ay; end
      default: begin
        w0 = $urandom_range(0, 100); w1 = $urandom_range(0, 100 - w0); w2 = 100 - w0 - w1;
        sx = (longint'(it.ax) * w0 + longint'(it.bx) * w1 + longint'(it.cx) * w2) / 100;
        sy = (longint'(it.ay) * w0 + longint'(it.by) * w1 + longint'(it.cy) * w2) / 100;
        it.px = coord_t'(sx); it.py = coord_t'(sy);
      end
    endcase
    return it;
  endfunction

  initial begin
    tri_item_t it;
    coord_t mx, mn;
    mx = 32'sh7FFFFFFF;
    mn = 32'sh80000000;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: plain inside, on edge, point on C, A equal B, parallel, outside, extremes
    send_item('{0, 0, 100 << 16, 10 << 16, 0, 200 << 16, 0, 10 << 16, 300 << 16,
                2 << 16, 2 << 16}, 1);
    send_item('{0, 0, 1, 10 << 16, 0, 2, 0, 10 << 16, 3, 5 << 16, 0}, 0);
    send_item('{0, 0, 1, 10 << 16, 0, 2, 0, 10 << 16, 3, 0, 10 << 16}, 0);
    send_item('{5, 5, 1, 5, 5, 2, 0, 100, 3, 4, 40}, 0);
    send_item('{0, 0, 1, 10, 0, 2, 0, 10, 3, 10, 10}, 0);
    send_item('{0, 0, 1, 10, 0, 2, 0, 10, 3, 50, 50}, 0);
    send_item('{0, 0, 1, 10, 0, 2, 0, 10, 3, 3, 0}, 0);
    send_item('{0, 0, 1, 0, 0, 2, 0, 0, 3, 0, 0}, 0);
    send_item('{mn, mn, mx, mx, mn, mn, mn, mx, mx, mn, mn}, 0);
    send_item('{mn, mn, mn, mx, mn, mx, mn, mx, mx, mn + 1, mn + 1}, 0);
    send_item('{mx, mx, mx, mn, mx, mn, mx, mn, mn, 0, 0}, 0);
    send_item('{mn, 0, mx, mx, 0, mx, 0, mx, mx, 0, 1}, 0);
    send_item('{mn, mn, mn, mx, mx, mn, mn, mx, mn, 0, 0}, 0);
    send_item('{-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1}, 0);

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_tolerance(16'd0);
        1: set_tolerance(16'hFFFF);
        2: set_tolerance(16'd1);
        3: set_tolerance(tol_t'($urandom));
        default: set_tolerance(SnapReset);
      endcase
      for (int n = 0; n < 320; n++) begin
        it = rand_item();
        send_item(it, (n / 40) % 3 == 0);
      end
    end

    in_if.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
